@@ hdl/rmq_pkg.sv @@
// Shared widths and types for the rotation-matrix-to-quaternion pipeline.
// No dependencies; every other file imports this package.
`default_nettype none

package rmq_pkg;

	// Element and result format: signed Q1.14
	localparam int ELEM_W  = 16;
	localparam int ONE_Q14 = 16384;

	// Clamped trace term, magnitude square root and norm widths
	localparam int T_W        = 17;
	localparam int T_SHIFT    = 28;
	localparam int MAG_IN_W   = 46;
	localparam int MAG_W      = MAG_IN_W / 2;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int NORM_IN_W  = 48;
	localparam int NORM_W     = NORM_IN_W / 2;

	// Final divide: (m * 2^14 + n/2) / n
	localparam int FRAC_W  = 14;
	localparam int NUM_W   = MAG_W + FRAC_W + 1;
	localparam int QUO_W   = FRAC_W + 1;

	localparam int LANES = 4;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [T_W-1:0]           trace_t;
	typedef logic [MAG_W-1:0]         mag_t;

	// Winning component index
	typedef enum logic [1:0] {
		WIN_W = 2'd0,
		WIN_X = 2'd1,
		WIN_Y = 2'd2,
		WIN_Z = 2'd3
	} win_t;

endpackage

`default_nettype wire

@@ hdl/rmq_front.sv @@
// Front end: trace combinations, clamping, winner pick and sign selection.
// Two register stages; depends on rmq_pkg.
`default_nettype none

module rmq_front import rmq_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     in_valid,
	input  wire elem_t                    c0_r0,
	input  wire elem_t                    c0_r1,
	input  wire elem_t                    c0_r2,
	input  wire elem_t                    c1_r0,
	input  wire elem_t                    c1_r1,
	input  wire elem_t                    c1_r2,
	input  wire elem_t                    c2_r0,
	input  wire elem_t                    c2_r1,
	input  wire elem_t                    c2_r2,
	output logic                          out_valid,
	output logic [LANES-1:0][T_W-1:0]     t,
	output logic [LANES-1:0]              neg
);

	localparam int S_W = T_W + 2;

	logic signed [S_W-1:0] e00, e11, e22, one_c;
	logic signed [S_W-1:0] s_nx [LANES];

	logic                  vld_s1;
	logic signed [S_W-1:0] s_s1 [LANES];
	logic                  d21_s1, d02_s1, d10_s1, a10_s1, a02_s1, a21_s1;

	logic                  vld_s2;
	logic [LANES-1:0][T_W-1:0] t_s2;
	logic [LANES-1:0]      neg_s2;

	logic [LANES-1:0][T_W-1:0] t_cl;
	trace_t                best;
	win_t                  win;
	logic [LANES-1:0]      neg_nx;

	// Form the four diagonal combinations
	always_comb begin
		e00   = S_W'(c0_r0);
		e11   = S_W'(c1_r1);
		e22   = S_W'(c2_r2);
		one_c = S_W'(ONE_Q14);
		s_nx[0] =  e00 + e11 + e22 + one_c;
		s_nx[1] =  e00 - e11 - e22 + one_c;
		s_nx[2] = -e00 + e11 - e22 + one_c;
		s_nx[3] = -e00 - e11 + e22 + one_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: hold the sums and the signs of the off-diagonal terms
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) s_s1[l] <= s_nx[l];
			d21_s1 <= (S_W'(c2_r1) - S_W'(c1_r2)) < 0;
			d02_s1 <= (S_W'(c0_r2) - S_W'(c2_r0)) < 0;
			d10_s1 <= (S_W'(c1_r0) - S_W'(c0_r1)) < 0;
			a10_s1 <= (S_W'(c1_r0) + S_W'(c0_r1)) < 0;
			a02_s1 <= (S_W'(c0_r2) + S_W'(c2_r0)) < 0;
			a21_s1 <= (S_W'(c2_r1) + S_W'(c1_r2)) < 0;
		end
	end

	// Clamp at zero and pick the largest, earliest on ties
	always_comb begin
		for (int l = 0; l < LANES; l++)
			t_cl[l] = (s_s1[l] < 0) ? '0 : s_s1[l][T_W-1:0];
		win  = WIN_W;
		best = t_cl[0];
		if (t_cl[1] > best) begin
			win  = WIN_X;
			best = t_cl[1];
		end
		if (t_cl[2] > best) begin
			win  = WIN_Y;
			best = t_cl[2];
		end
		if (t_cl[3] > best) begin
			win  = WIN_Z;
		end
		unique case (win)
			WIN_W: neg_nx = {d10_s1, d02_s1, d21_s1, 1'b0};
			WIN_X: neg_nx = {a02_s1, a10_s1, 1'b0, d21_s1};
			WIN_Y: neg_nx = {a21_s1, 1'b0, a10_s1, d02_s1};
			WIN_Z: neg_nx = {1'b0, a21_s1, a02_s1, d10_s1};
			default: neg_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2   <= t_cl;
			neg_s2 <= neg_nx;
		end
	end

	assign out_valid = vld_s2;
	assign t         = t_s2;
	assign neg       = neg_s2;

endmodule

`default_nettype wire

@@ hdl/rmq_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, several lanes.
// Carries a side payload alongside; depends on rmq_pkg.
`default_nettype none

module rmq_sqrt_pipe import rmq_pkg::*; #(
	parameter int NLANES = LANES,
	parameter int IN_W   = MAG_IN_W,
	parameter int SIDE_W = LANES,
	localparam int OUT_W = IN_W / 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic [NLANES-1:0][IN_W-1:0]   rad,
	input  wire logic [SIDE_W-1:0]             side,
	output logic                               out_valid,
	output logic [NLANES-1:0][OUT_W-1:0]       root,
	output logic [SIDE_W-1:0]                  out_side
);

	localparam int RW = OUT_W + 3;

	logic                          vld_s  [OUT_W];
	logic [NLANES-1:0][IN_W-1:0]   rad_s  [OUT_W];
	logic [NLANES-1:0][RW-1:0]     rem_s  [OUT_W];
	logic [NLANES-1:0][OUT_W-1:0]  root_s [OUT_W];
	logic [SIDE_W-1:0]             side_s [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic                          cur_vld;
		logic [NLANES-1:0][IN_W-1:0]   cur_rad;
		logic [NLANES-1:0][RW-1:0]     cur_rem;
		logic [NLANES-1:0][OUT_W-1:0]  cur_root;
		logic [SIDE_W-1:0]             cur_side;
		logic [NLANES-1:0][RW-1:0]     nx_rem;
		logic [NLANES-1:0][OUT_W-1:0]  nx_root;

		if (k == 0) begin : g_first
			assign cur_vld  = in_valid;
			assign cur_rad  = rad;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_side = side;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit
		always_comb begin
			logic [RW-1:0] r2;
			logic [RW-1:0] trial;
			for (int l = 0; l < NLANES; l++) begin
				r2    = {cur_rem[l][RW-3:0], cur_rad[l][IN_W-1 -: 2]};
				trial = RW'({cur_root[l], 2'b01});
				if (r2 >= trial) begin
					nx_rem[l]  = r2 - trial;
					nx_root[l] = {cur_root[l][OUT_W-2:0], 1'b1};
				end else begin
					nx_rem[l]  = r2;
					nx_root[l] = {cur_root[l][OUT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (adv) vld_s[k] <= cur_vld;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < NLANES; l++) rad_s[k][l] <= cur_rad[l] << 2;
				rem_s[k]  <= nx_rem;
				root_s[k] <= nx_root;
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[OUT_W-1];
	assign root      = root_s[OUT_W-1];
	assign out_side  = side_s[OUT_W-1];

endmodule

`default_nettype wire

@@ hdl/rmq_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
// The quotient must fit in QW bits; depends on rmq_pkg.
`default_nettype none

module rmq_div_pipe import rmq_pkg::*; #(
	parameter int NLANES = LANES,
	parameter int NW     = NUM_W,
	parameter int DW     = NORM_W,
	parameter int QW     = QUO_W,
	parameter int SIDE_W = LANES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        in_valid,
	input  wire logic [NLANES-1:0][NW-1:0]   num,
	input  wire logic [DW-1:0]               dvs,
	input  wire logic [SIDE_W-1:0]           side,
	output logic                             out_valid,
	output logic [NLANES-1:0][QW-1:0]        quo,
	output logic [SIDE_W-1:0]                out_side
);

	logic                         vld_s  [QW];
	logic [NLANES-1:0][QW-1:0]    low_s  [QW];
	logic [NLANES-1:0][DW-1:0]    rem_s  [QW];
	logic [NLANES-1:0][QW-1:0]    quo_s  [QW];
	logic [DW-1:0]                dvs_s  [QW];
	logic [SIDE_W-1:0]            side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                         cur_vld;
		logic [NLANES-1:0][QW-1:0]    cur_low;
		logic [NLANES-1:0][DW-1:0]    cur_rem;
		logic [NLANES-1:0][QW-1:0]    cur_quo;
		logic [DW-1:0]                cur_dvs;
		logic [SIDE_W-1:0]            cur_side;
		logic [NLANES-1:0][DW-1:0]    nx_rem;
		logic [NLANES-1:0][QW-1:0]    nx_quo;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < NLANES; l++) begin
					cur_low[l] = num[l][QW-1:0];
					cur_rem[l] = DW'(num[l][NW-1:QW]);
				end
			end
			assign cur_vld  = in_valid;
			assign cur_quo  = '0;
			assign cur_dvs  = dvs;
			assign cur_side = side;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_low  = low_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_quo  = quo_s[k-1];
			assign cur_dvs  = dvs_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// Shift in one dividend bit and subtract when it fits
		always_comb begin
			logic [DW:0] r2;
			logic [DW:0] diff;
			for (int l = 0; l < NLANES; l++) begin
				r2   = {cur_rem[l], cur_low[l][QW-1]};
				diff = r2 - {1'b0, cur_dvs};
				if (r2 >= {1'b0, cur_dvs}) begin
					nx_rem[l] = diff[DW-1:0];
					nx_quo[l] = {cur_quo[l][QW-2:0], 1'b1};
				end else begin
					nx_rem[l] = r2[DW-1:0];
					nx_quo[l] = {cur_quo[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (adv) vld_s[k] <= cur_vld;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < NLANES; l++) low_s[k][l] <= cur_low[l] << 1;
				rem_s[k]  <= nx_rem;
				quo_s[k]  <= nx_quo;
				dvs_s[k]  <= cur_dvs;
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

`default_nettype wire

@@ hdl/rotation_matrix_to_quaternion.sv @@
// Top level of the rotation-matrix-to-quaternion converter.
// Uses rmq_pkg, rmq_front, rmq_sqrt_pipe and rmq_div_pipe.
`default_nettype none

// Converts a 3x3 rotation matrix (signed Q1.14, element cI_rJ is column I,
// row J) to a unit quaternion in signed Q1.14. Fully pipelined: a new
// transaction may be accepted every cycle while the output side does not stall.
// The data passes 68 register stages, most of them in the bit-per-stage
// square roots (23 stages for the component magnitudes, 24 for the norm)
// and the 15-stage divider. The whole pipeline holds while a finished
// result waits on out_ready; in_ready is low only then. Any input bit
// pattern is processed; there is no kept state.

module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire elem_t       c0_r0,
	input  wire elem_t       c0_r1,
	input  wire elem_t       c0_r2,
	input  wire elem_t       c1_r0,
	input  wire elem_t       c1_r1,
	input  wire elem_t       c1_r2,
	input  wire elem_t       c2_r0,
	input  wire elem_t       c2_r1,
	input  wire elem_t       c2_r2,
	output logic             out_valid,
	input  wire logic        out_ready,
	output elem_t            quat_w,
	output elem_t            quat_x,
	output elem_t            quat_y,
	output elem_t            quat_z
);

	localparam int SIDE_NORM_W = LANES * MAG_W + LANES;

	logic adv;

	logic                           f_vld;
	logic [LANES-1:0][T_W-1:0]      f_t;
	logic [LANES-1:0]               f_neg;
	logic [LANES-1:0][MAG_IN_W-1:0] m_rad;

	logic                           m_vld;
	logic [LANES-1:0][MAG_W-1:0]    m_root;
	logic [LANES-1:0]               m_neg;

	logic                           vld_s3;
	logic [LANES-1:0][SQ_W-1:0]     sq_s3;
	logic [LANES-1:0][MAG_W-1:0]    mag_s3;
	logic [LANES-1:0]               neg_s3;

	logic                           vld_s4;
	logic [NORM_IN_W-1:0]           sum_s4;
	logic [LANES-1:0][MAG_W-1:0]    mag_s4;
	logic [LANES-1:0]               neg_s4;

	logic                           n_vld;
	logic [0:0][NORM_W-1:0]         n_root;
	logic [SIDE_NORM_W-1:0]         n_side;
	logic [LANES-1:0][MAG_W-1:0]    n_mag;
	logic [LANES-1:0]               n_neg;

	logic                           vld_s5;
	logic [LANES-1:0][NUM_W-1:0]    num_s5;
	logic [NORM_W-1:0]              dvs_s5;
	logic [LANES-1:0]               neg_s5;

	logic                           d_vld;
	logic [LANES-1:0][QUO_W-1:0]    d_quo;
	logic [LANES-1:0]               d_neg;

	logic                           out_valid_q;
	logic [LANES-1:0][ELEM_W-1:0]   quat_q;
	logic [LANES-1:0][ELEM_W-1:0]   quat_nx;

	// Advance the whole pipeline unless a result is held at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	rmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.c0_r0     (c0_r0),
		.c0_r1     (c0_r1),
		.c0_r2     (c0_r2),
		.c1_r0     (c1_r0),
		.c1_r1     (c1_r1),
		.c1_r2     (c1_r2),
		.c2_r0     (c2_r0),
		.c2_r1     (c2_r1),
		.c2_r2     (c2_r2),
		.out_valid (f_vld),
		.t         (f_t),
		.neg       (f_neg)
	);

	// Scale each trace term into Q.42 before the root
	always_comb begin
		for (int l = 0; l < LANES; l++)
			m_rad[l] = MAG_IN_W'({f_t[l], {T_SHIFT{1'b0}}});
	end

	rmq_sqrt_pipe #(
		.NLANES (LANES),
		.IN_W   (MAG_IN_W),
		.SIDE_W (LANES)
	) u_mag_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_vld),
		.rad       (m_rad),
		.side      (f_neg),
		.out_valid (m_vld),
		.root      (m_root),
		.out_side  (m_neg)
	);

	// Square the magnitudes, then add them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= m_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= n_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) sq_s3[l] <= m_root[l] * m_root[l];
			mag_s3 <= m_root;
			neg_s3 <= m_neg;
			sum_s4 <= NORM_IN_W'(sq_s3[0]) + NORM_IN_W'(sq_s3[1])
			        + NORM_IN_W'(sq_s3[2]) + NORM_IN_W'(sq_s3[3]);
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	rmq_sqrt_pipe #(
		.NLANES (1),
		.IN_W   (NORM_IN_W),
		.SIDE_W (SIDE_NORM_W)
	) u_norm_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s4),
		.rad       (sum_s4),
		.side      ({mag_s4, neg_s4}),
		.out_valid (n_vld),
		.root      (n_root),
		.out_side  (n_side)
	);

	assign n_mag = n_side[SIDE_NORM_W-1:LANES];
	assign n_neg = n_side[LANES-1:0];

	// Form m * 2^14 + n/2 for the rounded divide
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++)
				num_s5[l] <= NUM_W'({n_mag[l], {FRAC_W{1'b0}}})
				           + NUM_W'(n_root[0] >> 1);
			dvs_s5 <= n_root[0];
			neg_s5 <= n_neg;
		end
	end

	rmq_div_pipe #(
		.NLANES (LANES),
		.NW     (NUM_W),
		.DW     (NORM_W),
		.QW     (QUO_W),
		.SIDE_W (LANES)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s5),
		.num       (num_s5),
		.dvs       (dvs_s5),
		.side      (neg_s5),
		.out_valid (d_vld),
		.quo       (d_quo),
		.out_side  (d_neg)
	);

	// Clamp to one and apply the sign
	always_comb begin
		logic [QUO_W-1:0]  mag;
		logic [ELEM_W-1:0] val;
		for (int l = 0; l < LANES; l++) begin
			mag = (d_quo[l] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : d_quo[l];
			val = ELEM_W'(mag);
			quat_nx[l] = d_neg[l] ? (ELEM_W'(0) - val) : val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= d_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) quat_q <= quat_nx;
	end

	assign out_valid = out_valid_q;
	assign quat_w    = quat_q[0];
	assign quat_x    = quat_q[1];
	assign quat_y    = quat_q[2];
	assign quat_z    = quat_q[3];

	// Every component stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(quat_w) <= 16'sd16384 && $signed(quat_w) >= -16'sd16384 &&
		               $signed(quat_x) <= 16'sd16384 && $signed(quat_x) >= -16'sd16384 &&
		               $signed(quat_y) <= 16'sd16384 && $signed(quat_y) >= -16'sd16384 &&
		               $signed(quat_z) <= 16'sd16384 && $signed(quat_z) >= -16'sd16384))
		else $error("quaternion component out of range");

	// The winning component is positive and at least one half
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(quat_w) >= 16'sd8192 || $signed(quat_x) >= 16'sd8192 ||
		               $signed(quat_y) >= 16'sd8192 || $signed(quat_z) >= 16'sd8192))
		else $error("no dominant quaternion component");

	// The norm bounds every magnitude, so the quotient fits
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		n_vld |-> (NORM_W'(n_mag[0]) <= n_root[0] && NORM_W'(n_mag[1]) <= n_root[0] &&
		           NORM_W'(n_mag[2]) <= n_root[0] && NORM_W'(n_mag[3]) <= n_root[0] &&
		           n_root[0] != '0))
		else $error("norm smaller than a component magnitude");

endmodule

`default_nettype wire
